>>> rtl/vlru_pkg.sv
package vlru_pkg;

   // configuration port
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_RECORD_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MEMBER_LENGTH = 2'd1;

   // record_mode codes; the remaining two codes select the filtered stream
   localparam logic [1:0] MODE_RAW    = 2'd0;
   localparam logic [1:0] MODE_RECORD = 2'd1;
   localparam logic [1:0] MODE_RESET  = MODE_RECORD;

   // record parser phases
   localparam logic [1:0] PH_LOW  = 2'd0;
   localparam logic [1:0] PH_HIGH = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;
   localparam logic [1:0] PH_PAD  = 2'd3;

   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_NL  = 8'h0A;
   localparam logic [7:0] CH_NUL = 8'h00;

   localparam int RECORD_LEN_W = 16;

   // front-to-back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   // one queue entry: the one or two results of one input byte
   typedef struct packed {
      logic [7:0] data0;
      logic       clamp0;
      logic       has_second;
      logic [7:0] data1;
      logic       clamp1;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // bytes that survive the CR / NUL filter
   function automatic logic kept(input logic [7:0] b);
      return (b != CH_CR) && (b != CH_NUL);
   endfunction

endpackage

>>> rtl/var_length_record_unpacker.sv
// Channel | Direction | Ports
// --------+-----------+------------------------------------------------------------
// req     | in        | req_valid, req_stall, req_in_byte
// rsp     | out       | rsp_valid, rsp_stall, rsp_out_byte, rsp_run_last,
//         |           | rsp_record_clamped
// csr     | in        | csr_write_enable, csr_index, csr_write_data
//
// One byte is taken per cycle unless the queue is full, which alone raises req_stall;
// the front parses it in the cycle it is accepted. Results leave the output register
// at one per cycle unless stalled; a byte ending a record with a kept data byte
// yields two, which a four-entry queue between front and back absorbs. rsp_valid
// rises once a result has passed queue and output register. Synchronous reset sets
// record mode and a zero member length, so no result appears until one is written.
module var_length_record_unpacker #(
   parameter int MEMBER_LEN_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [vlru_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [vlru_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_in_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_run_last,
   output logic                             rsp_record_clamped
);
   import vlru_pkg::*;

   queue_status_type q_status;
   entry_type        push_entry;
   entry_type        head_entry;
   logic             push;
   logic             pop;

   assign req_stall = q_status.full;

   // parser front
   vlru_front #(
      .MEMBER_LEN_BITS(MEMBER_LEN_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_in_byte      (req_in_byte),
      .q_status         (q_status),
      .push             (push),
      .push_entry       (push_entry)
   );

   // decoupling queue
   vlru_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   // result sequencer
   vlru_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_entry         (head_entry),
      .q_status           (q_status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_run_last       (rsp_run_last),
      .rsp_record_clamped (rsp_record_clamped)
   );

endmodule

>>> rtl/vlru_front.sv
module vlru_front #(
   parameter int MEMBER_LEN_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [vlru_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [vlru_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                                req_valid,
   input  logic [7:0]                          req_in_byte,
   input  vlru_pkg::queue_status_type          q_status,
   output logic                                push,
   output vlru_pkg::entry_type                 push_entry
);
   import vlru_pkg::*;

   logic [1:0]                 mode_ff, mode_in;
   logic [1:0]                 phase_ff, phase_in;
   logic [MEMBER_LEN_BITS-1:0] member_left_ff, member_left_in;
   logic [RECORD_LEN_W-1:0]    record_left_ff, record_left_in;
   logic [7:0]                 length_low_ff, length_low_in;
   logic                       pad_ff, pad_in;
   logic                       clamped_ff, clamped_in;

   logic                       accept;
   logic                       active;
   logic [MEMBER_LEN_BITS-1:0] ml_dec;
   logic [RECORD_LEN_W-1:0]    len_raw;
   logic [RECORD_LEN_W-1:0]    len_cut;
   logic                       len_over;
   logic [RECORD_LEN_W-1:0]    rl_dec;
   logic                       byte_kept;
   logic [1:0]                 n_res;
   entry_type                  entry;

   assign accept    = req_valid && !q_status.full;
   assign active    = accept && (member_left_ff != '0);
   assign ml_dec    = member_left_ff - 1'b1;
   assign len_raw   = {req_in_byte, length_low_ff};
   assign len_over  = MEMBER_LEN_BITS'(len_raw) > ml_dec;
   assign len_cut   = len_over ? ml_dec[RECORD_LEN_W-1:0] : len_raw;
   assign rl_dec    = (record_left_ff != '0) ? record_left_ff - 1'b1 : record_left_ff;
   assign byte_kept = kept(req_in_byte);

   // classify the byte and work out the next state and its results
   always_comb begin
      mode_in        = mode_ff;
      phase_in       = phase_ff;
      member_left_in = member_left_ff;
      record_left_in = record_left_ff;
      length_low_in  = length_low_ff;
      pad_in         = pad_ff;
      clamped_in     = clamped_ff;
      n_res          = 2'd0;
      entry          = '0;

      priority if (csr_write_enable) begin
         unique case (csr_index)
            REG_RECORD_MODE: begin
               mode_in = csr_write_data[1:0];
            end
            REG_MEMBER_LENGTH: begin
               // new member: reload and clear the record state
               member_left_in = csr_write_data[MEMBER_LEN_BITS-1:0];
               phase_in       = PH_LOW;
               record_left_in = '0;
               length_low_in  = '0;
               pad_in         = 1'b0;
               clamped_in     = 1'b0;
            end
            default: begin
            end
         endcase
      end else if (active) begin
         member_left_in = ml_dec;
         priority if (mode_ff == MODE_RAW) begin
            n_res       = 2'd1;
            entry.data0 = req_in_byte;
         end else if (mode_ff != MODE_RECORD) begin
            if (byte_kept) begin
               n_res       = 2'd1;
               entry.data0 = req_in_byte;
            end
         end else begin
            unique case (phase_ff)
               PH_LOW: begin
                  length_low_in = req_in_byte;
                  if (ml_dec == '0) begin
                     // length cut off by end of member
                     clamped_in   = 1'b1;
                     n_res        = 2'd1;
                     entry.data0  = CH_NL;
                     entry.clamp0 = 1'b1;
                  end else begin
                     phase_in = PH_HIGH;
                  end
               end
               PH_HIGH: begin
                  pad_in         = len_raw[0];
                  clamped_in     = len_over;
                  record_left_in = len_cut;
                  if (len_cut == '0) begin
                     n_res        = 2'd1;
                     entry.data0  = CH_NL;
                     entry.clamp0 = len_over;
                     phase_in     = (len_raw[0] && (ml_dec != '0)) ? PH_PAD : PH_LOW;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
               PH_DATA: begin
                  record_left_in = rl_dec;
                  if (byte_kept) begin
                     entry.data0  = req_in_byte;
                     entry.clamp0 = clamped_ff;
                     if (rl_dec == '0) begin
                        n_res            = 2'd2;
                        entry.has_second = 1'b1;
                        entry.data1      = CH_NL;
                        entry.clamp1     = clamped_ff;
                     end else begin
                        n_res = 2'd1;
                     end
                  end else if (rl_dec == '0) begin
                     n_res        = 2'd1;
                     entry.data0  = CH_NL;
                     entry.clamp0 = clamped_ff;
                  end
                  if (rl_dec == '0) begin
                     phase_in = (pad_ff && (ml_dec != '0)) ? PH_PAD : PH_LOW;
                  end
               end
               PH_PAD: begin
                  phase_in = PH_LOW;
               end
               default: begin
                  phase_in = PH_LOW;
               end
            endcase
         end
      end
   end

   assign push       = active && !csr_write_enable && (n_res != 2'd0);
   assign push_entry = entry;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_RESET;
         phase_ff       <= PH_LOW;
         member_left_ff <= '0;
         record_left_ff <= '0;
         length_low_ff  <= '0;
         pad_ff         <= 1'b0;
         clamped_ff     <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         phase_ff       <= phase_in;
         member_left_ff <= member_left_in;
         record_left_ff <= record_left_in;
         length_low_ff  <= length_low_in;
         pad_ff         <= pad_in;
         clamped_ff     <= clamped_in;
      end
   end

endmodule

>>> rtl/vlru_queue.sv
module vlru_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  vlru_pkg::entry_type        push_entry,
   input  logic                       pop,
   output vlru_pkg::entry_type        head_entry,
   output vlru_pkg::queue_status_type q_status
);
   import vlru_pkg::*;

   entry_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_entry     = mem_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/vlru_back.sv
module vlru_back (
   input  logic                       clock,
   input  logic                       reset,
   input  vlru_pkg::entry_type        head_entry,
   input  vlru_pkg::queue_status_type q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_run_last,
   output logic                       rsp_record_clamped
);
   import vlru_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_data_ff, out_data_in;
   logic       out_last_ff, out_last_in;
   logic       out_clamp_ff, out_clamp_in;
   logic       sec_valid_ff, sec_valid_in;
   logic [7:0] sec_data_ff, sec_data_in;
   logic       sec_clamp_ff, sec_clamp_in;
   logic       out_free;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign pop      = out_free && !sec_valid_ff && !q_status.empty;

   // load the output register: pending second result first, then the queue head
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_clamp_in = out_clamp_ff;
      sec_valid_in = sec_valid_ff;
      sec_data_in  = sec_data_ff;
      sec_clamp_in = sec_clamp_ff;
      if (out_free) begin
         priority if (sec_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = sec_data_ff;
            out_last_in  = 1'b1;
            out_clamp_in = sec_clamp_ff;
            sec_valid_in = 1'b0;
         end else if (!q_status.empty) begin
            out_valid_in = 1'b1;
            out_data_in  = head_entry.data0;
            out_last_in  = !head_entry.has_second;
            out_clamp_in = head_entry.clamp0;
            sec_valid_in = head_entry.has_second;
            sec_data_in  = head_entry.data1;
            sec_clamp_in = head_entry.clamp1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      out_last_ff  <= out_last_in;
      out_clamp_ff <= out_clamp_in;
      sec_data_ff  <= sec_data_in;
      sec_clamp_ff <= sec_clamp_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_byte       = out_data_ff;
   assign rsp_run_last       = out_last_ff;
   assign rsp_record_clamped = out_clamp_ff;

endmodule
